>>> rtl/core/xxh64_pkg.sv
// shared constants, types and helpers for the xxh64 digest engine
`timescale 1ns / 1ps

package xxh64_pkg;

    // xxh64 primes
    localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
    localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
    localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
    localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
    localparam logic [63:0] PRIME5 = 64'd2870177450012600261;

    localparam int NUM_LANES = 4;
    localparam logic [5:0] STRIPE_BYTES = 6'd32;

    // four 64-bit words, word 0 in the low bits
    typedef logic [NUM_LANES-1:0][63:0] t_quad;

    // lane operations
    typedef enum logic [1:0] {
        LOP_ROUND,
        LOP_MIXA,
        LOP_MIXW
    } t_lane_op;

    typedef struct packed {
        logic     go;
        t_lane_op op;
    } t_lane_cmd;

    // top-level control states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ROUND_GO,
        S_ROUND_WAIT,
        S_MIXA_GO,
        S_MIXA_WAIT,
        S_MIXW_GO,
        S_MIXW_WAIT,
        S_FIN_GO,
        S_FIN_WAIT,
        S_PUSH
    } t_state;

    // finalizer states
    typedef enum logic [3:0] {
        F_IDLE,
        F_MERGE,
        F_LEN,
        F_WORD,
        F_HALF_A,
        F_HALF_B,
        F_BYTE_A,
        F_BYTE_B,
        F_AV1,
        F_AV2,
        F_DONE
    } t_fstate;

    // rotate left by a constant amount in 1..63
    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        logic [127:0] d;
        d = {x, x} << r;
        return d[127:64];
    endfunction

endpackage

>>> rtl/core/xxh64_if.sv
// valid/ready channels of the xxh64 digest engine
`timescale 1ns / 1ps

interface xxh64_stripe_if;
    logic        valid;
    logic        ready;
    logic [63:0] stripe_word0;
    logic [63:0] stripe_word1;
    logic [63:0] stripe_word2;
    logic [63:0] stripe_word3;
    logic [5:0]  valid_bytes;
    logic        is_final;

    modport source (output valid, stripe_word0, stripe_word1, stripe_word2, stripe_word3,
                    valid_bytes, is_final, input ready);
    modport sink (input valid, stripe_word0, stripe_word1, stripe_word2, stripe_word3,
                  valid_bytes, is_final, output ready);
endinterface

interface xxh64_digest_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest;

    modport source (output valid, digest, input ready);
    modport sink (input valid, digest, output ready);
endinterface

interface xxh64_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] seed_value;

    modport source (output valid, seed_value, input ready);
    modport sink (input valid, seed_value, output ready);
endinterface

>>> rtl/core/xxh64_mul.sv
// two-stage 64x64 multiplier, low 64 bits of the product
`timescale 1ns / 1ps

module xxh64_mul
    import xxh64_pkg::*;
(
    input  logic        i_clk,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_ll;
    logic [31:0] r_x;
    logic [63:0] w_ll;
    logic [31:0] w_x;

    // partial products: low x low in full, cross terms only in their low half
    assign w_ll = {32'b0, i_a[31:0]} * {32'b0, i_b[31:0]};
    assign w_x  = i_a[31:0] * i_b[63:32] + i_a[63:32] * i_b[31:0];

    always_ff @(posedge i_clk) begin
        r_ll <= w_ll;
        r_x  <= w_x;
    end

    // recombine
    assign o_p = r_ll + {r_x, 32'b0};

endmodule

>>> rtl/core/xxh64_lane.sv
// one lane: accumulator and round unit with its own multiplier
`timescale 1ns / 1ps

module xxh64_lane
    import xxh64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic [63:0] i_init,
    input  t_lane_cmd   i_cmd,
    input  logic [63:0] i_word,
    output logic [63:0] o_acc,
    output logic [63:0] o_mixa,
    output logic [63:0] o_mixw,
    output logic        o_done
);

    logic        r_busy;
    logic [1:0]  r_ph;
    t_lane_op    r_op;
    logic [63:0] r_acc;
    logic [63:0] r_mixa;
    logic [63:0] r_mixw;
    logic [63:0] r_t;
    logic [63:0] w_y;
    logic [63:0] w_base;
    logic [63:0] w_ma;
    logic [63:0] w_mb;
    logic [63:0] w_prod;

    // operand and base of the round for the current op
    always_comb begin
        case (r_op)
            LOP_ROUND: begin
                w_y    = i_word;
                w_base = r_acc;
            end
            LOP_MIXA: begin
                w_y    = r_acc;
                w_base = 64'd0;
            end
            default: begin
                w_y    = i_word;
                w_base = 64'd0;
            end
        endcase
    end

    // first multiply by prime two, second by prime one
    assign w_ma = r_ph[1] ? r_t : w_y;
    assign w_mb = r_ph[1] ? PRIME1 : PRIME2;

    xxh64_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    // phase sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= 2'd0;
            r_op   <= LOP_ROUND;
        end else if (i_cmd.go) begin
            r_busy <= 1'b1;
            r_ph   <= 2'd0;
            r_op   <= i_cmd.op;
        end else if (r_busy) begin
            r_ph <= r_ph + 2'd1;
            if (r_ph == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    // accumulator and mix results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 64'd0;
        end else if (i_load) begin
            r_acc <= i_init;
        end else if (o_done && r_op == LOP_ROUND) begin
            r_acc <= w_prod;
        end
        if (r_busy && r_ph == 2'd1) begin
            r_t <= rotl64(w_base + w_prod, 31);
        end
        if (o_done && r_op == LOP_MIXA) begin
            r_mixa <= w_prod;
        end
        if (o_done && r_op == LOP_MIXW) begin
            r_mixw <= w_prod;
        end
    end

    assign o_done = r_busy && (r_ph == 2'd3);
    assign o_acc  = r_acc;
    assign o_mixa = r_mixa;
    assign o_mixw = r_mixw;

endmodule

>>> rtl/core/xxh64_final.sv
// merge stage: lane merge, length, tail and avalanche on one shared multiplier
`timescale 1ns / 1ps

module xxh64_final
    import xxh64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_had,
    input  logic [63:0] i_len,
    input  logic [5:0]  i_v,
    input  logic [63:0] i_seed,
    input  t_quad       i_acc,
    input  t_quad       i_mixa,
    input  t_quad       i_mixw,
    input  t_quad       i_words,
    output logic        o_done,
    output logic [63:0] o_digest
);

    t_fstate      r_state, n_state;
    logic         r_ph, n_ph;
    logic [1:0]   r_i, n_i;
    logic [4:0]   r_p, n_p;
    logic [63:0]  r_h, n_h;
    logic [63:0]  r_k, n_k;
    logic [63:0]  w_ma;
    logic [63:0]  w_mb;
    logic [63:0]  w_prod;
    logic [255:0] w_flat;
    logic [7:0]   w_byte;
    logic [31:0]  w_half;
    logic [1:0]   w_nw;
    logic [63:0]  w_rotsum;
    t_fstate      w_after_word;
    t_fstate      w_after_half;

    assign w_flat   = i_words;
    assign w_byte   = w_flat[{r_p, 3'b000} +: 8];
    assign w_half   = i_words[r_p[4:3]][31:0];
    assign w_nw     = i_v[4:3];
    assign w_rotsum = rotl64(i_acc[0], 1) + rotl64(i_acc[1], 7)
                    + rotl64(i_acc[2], 12) + rotl64(i_acc[3], 18);

    // tail routing
    always_comb begin
        if (i_v[2]) begin
            w_after_word = F_HALF_A;
        end else if (i_v[1:0] != 2'd0) begin
            w_after_word = F_BYTE_A;
        end else begin
            w_after_word = F_AV1;
        end
        w_after_half = (i_v[1:0] != 2'd0) ? F_BYTE_A : F_AV1;
    end

    // multiplier operands per step
    always_comb begin
        case (r_state)
            F_MERGE: begin
                w_ma = r_h ^ i_mixa[r_i];
                w_mb = PRIME1;
            end
            F_WORD: begin
                w_ma = rotl64(r_h ^ i_mixw[r_i], 27);
                w_mb = PRIME1;
            end
            F_HALF_A: begin
                w_ma = {32'b0, w_half};
                w_mb = PRIME1;
            end
            F_HALF_B: begin
                w_ma = rotl64(r_h ^ r_k, 23);
                w_mb = PRIME2;
            end
            F_BYTE_A: begin
                w_ma = {56'b0, w_byte};
                w_mb = PRIME5;
            end
            F_BYTE_B: begin
                w_ma = rotl64(r_h ^ r_k, 11);
                w_mb = PRIME1;
            end
            F_AV1: begin
                w_ma = r_h ^ (r_h >> 33);
                w_mb = PRIME2;
            end
            F_AV2: begin
                w_ma = r_h ^ (r_h >> 29);
                w_mb = PRIME3;
            end
            default: begin
                w_ma = 64'd0;
                w_mb = 64'd0;
            end
        endcase
    end

    xxh64_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    // step sequencer: each multiply step latches in phase 0, consumes in phase 1
    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_i     = r_i;
        n_p     = r_p;
        n_h     = r_h;
        n_k     = r_k;
        unique case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    n_h     = i_had ? w_rotsum : i_seed + PRIME5;
                    n_i     = 2'd0;
                    n_ph    = 1'b0;
                    n_state = i_had ? F_MERGE : F_LEN;
                end
            end
            F_MERGE: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_h = w_prod + PRIME4;
                    n_i = r_i + 2'd1;
                    if (r_i == 2'd3) begin
                        n_state = F_LEN;
                    end
                end
            end
            F_LEN: begin
                n_h     = r_h + i_len;
                n_i     = 2'd0;
                n_p     = 5'd0;
                n_ph    = 1'b0;
                n_state = (w_nw != 2'd0) ? F_WORD : w_after_word;
            end
            F_WORD: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_h = w_prod + PRIME4;
                    n_i = r_i + 2'd1;
                    n_p = r_p + 5'd8;
                    if (r_i + 2'd1 == w_nw) begin
                        n_state = w_after_word;
                    end
                end
            end
            F_HALF_A: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_k     = w_prod;
                    n_state = F_HALF_B;
                end
            end
            F_HALF_B: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_h     = w_prod + PRIME3;
                    n_p     = r_p + 5'd4;
                    n_state = w_after_half;
                end
            end
            F_BYTE_A: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_k     = w_prod;
                    n_state = F_BYTE_B;
                end
            end
            F_BYTE_B: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_h     = w_prod;
                    n_p     = r_p + 5'd1;
                    n_state = ({1'b0, r_p} + 6'd1 == i_v) ? F_AV1 : F_BYTE_A;
                end
            end
            F_AV1: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_h     = w_prod;
                    n_state = F_AV2;
                end
            end
            F_AV2: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_h     = w_prod;
                    n_state = F_DONE;
                end
            end
            F_DONE: begin
                n_state = F_IDLE;
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_ph    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
        end
        r_i <= n_i;
        r_p <= n_p;
        r_h <= n_h;
        r_k <= n_k;
    end

    // last avalanche xor-shift
    assign o_done   = (r_state == F_DONE);
    assign o_digest = r_h ^ (r_h >> 32);

endmodule

>>> rtl/core/xxhash_64bit_digest_top.sv
// xxh64 digest engine: four parallel lanes, merge stage and output register
//
// Computes the 64-bit xxHash of a message that arrives as 32-byte stripes. For a full
// stripe each lane round runs two chained 64-bit multiplies through a two-stage
// multiplier, four lanes side by side. The last beat adds two lane mix passes and the
// finalizer, which uses one multiplier for all its multiplies; the steps it runs depend
// on message size and tail length. The digest sits in an output register, so the
// next message can start while it waits to be taken. The seed register accepts a
// write every cycle and is used at message start and at the end of a short message.
`timescale 1ns / 1ps

module xxhash_64bit_digest_top
    import xxh64_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    xxh64_cfg_if.sink       i_cfg,
    xxh64_stripe_if.sink    i_stripe,
    xxh64_digest_if.source  o_digest
);

    t_state      r_state, n_state;
    logic [63:0] r_seed;
    t_quad       r_w;
    logic [5:0]  r_v;
    logic        r_fin;
    logic [63:0] r_total;
    logic        r_inmsg;
    logic [63:0] r_dig;
    logic        r_ov;
    logic [63:0] r_out;

    logic        w_acc_in;
    logic        w_push;
    logic [5:0]  w_vsat;
    t_quad       w_init;
    t_quad       w_lacc;
    t_quad       w_mixa;
    t_quad       w_mixw;
    logic [3:0]  w_ldone;
    t_lane_cmd   w_cmd;
    logic        w_fdone;
    logic [63:0] w_fdig;

    // configuration: always ready
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 64'd0;
        end else if (i_cfg.valid) begin
            r_seed <= i_cfg.seed_value;
        end
    end

    // input beat
    assign i_stripe.ready = (r_state == S_IDLE);
    assign w_acc_in       = i_stripe.valid && i_stripe.ready;
    assign w_vsat = (i_stripe.valid_bytes > STRIPE_BYTES) ? STRIPE_BYTES
                                                         : i_stripe.valid_bytes;

    // lane seeds
    assign w_init[0] = r_seed + PRIME1 + PRIME2;
    assign w_init[1] = r_seed + PRIME2;
    assign w_init[2] = r_seed;
    assign w_init[3] = r_seed - PRIME1;

    // lane command
    always_comb begin
        w_cmd.go = 1'b0;
        w_cmd.op = LOP_ROUND;
        case (r_state)
            S_ROUND_GO: w_cmd.go = 1'b1;
            S_MIXA_GO: begin
                w_cmd.go = 1'b1;
                w_cmd.op = LOP_MIXA;
            end
            S_MIXW_GO: begin
                w_cmd.go = 1'b1;
                w_cmd.op = LOP_MIXW;
            end
            default: w_cmd.go = 1'b0;
        endcase
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        xxh64_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (w_acc_in && !r_inmsg),
            .i_init  (w_init[g]),
            .i_cmd   (w_cmd),
            .i_word  (r_w[g]),
            .o_acc   (w_lacc[g]),
            .o_mixa  (w_mixa[g]),
            .o_mixw  (w_mixw[g]),
            .o_done  (w_ldone[g])
        );
    end

    xxh64_final u_final (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_FIN_GO),
        .i_had    (r_total != 64'd0),
        .i_len    (r_total + {58'd0, r_v}),
        .i_v      (r_v),
        .i_seed   (r_seed),
        .i_acc    (w_lacc),
        .i_mixa   (w_mixa),
        .i_mixw   (w_mixw),
        .i_words  (r_w),
        .o_done   (w_fdone),
        .o_digest (w_fdig)
    );

    // output register loads when free or being emptied
    assign w_push = (r_state == S_PUSH) && (!r_ov || o_digest.ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc_in) begin
                    n_state = (!i_stripe.is_final || w_vsat == STRIPE_BYTES) ? S_ROUND_GO
                                                                            : S_MIXA_GO;
                end
            end
            S_ROUND_GO:   n_state = S_ROUND_WAIT;
            S_ROUND_WAIT: begin
                if (w_ldone[0]) begin
                    n_state = r_fin ? S_MIXA_GO : S_IDLE;
                end
            end
            S_MIXA_GO:    n_state = S_MIXA_WAIT;
            S_MIXA_WAIT:  n_state = w_ldone[0] ? S_MIXW_GO : S_MIXA_WAIT;
            S_MIXW_GO:    n_state = S_MIXW_WAIT;
            S_MIXW_WAIT:  n_state = w_ldone[0] ? S_FIN_GO : S_MIXW_WAIT;
            S_FIN_GO:     n_state = S_FIN_WAIT;
            S_FIN_WAIT:   n_state = w_fdone ? S_PUSH : S_FIN_WAIT;
            S_PUSH:       n_state = w_push ? S_IDLE : S_PUSH;
            default:      n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // message bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= 64'd0;
            r_inmsg <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            if (w_acc_in) begin
                r_fin <= i_stripe.is_final;
                if (!r_inmsg) begin
                    r_total <= 64'd0;
                    r_inmsg <= 1'b1;
                end
            end else if (r_state == S_ROUND_WAIT && w_ldone[0]) begin
                r_total <= r_total + 64'd32;
            end
            if (w_push) begin
                r_inmsg <= 1'b0;
            end
        end
    end

    // beat payload and digest holding
    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_w[0] <= i_stripe.stripe_word0;
            r_w[1] <= i_stripe.stripe_word1;
            r_w[2] <= i_stripe.stripe_word2;
            r_w[3] <= i_stripe.stripe_word3;
            r_v    <= (i_stripe.is_final && w_vsat != STRIPE_BYTES) ? w_vsat : 6'd0;
        end
        if (r_state == S_FIN_WAIT && w_fdone) begin
            r_dig <= w_fdig;
        end
        if (w_push) begin
            r_out <= r_dig;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_push) begin
            r_ov <= 1'b1;
        end else if (o_digest.ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_digest.valid  = r_ov;
    assign o_digest.digest = r_out;

    // lanes run in lockstep
    a_lane_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ldone == 4'b0000) || (w_ldone == 4'b1111))
        else $error("lanes finished out of step");

    // lane completion only while waiting for it
    a_lane_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ldone[0] |-> (r_state == S_ROUND_WAIT || r_state == S_MIXA_WAIT
                        || r_state == S_MIXW_WAIT))
        else $error("lane done outside a wait state");

    // finalizer completes only while the controller waits for it
    a_fin_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fdone |-> (r_state == S_FIN_WAIT))
        else $error("finalizer done outside its wait state");

    // byte total counts whole stripes
    a_total_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total[4:0] == 5'd0)
        else $error("byte total not a multiple of a stripe");

    // a pushed digest closes the message
    a_push_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> (!r_inmsg && r_ov))
        else $error("message still open after digest push");

endmodule

>>> bench/tb.sv
// self-checking bench for the xxh64 digest engine
`timescale 1ns / 1ps

module tb;
    import xxh64_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 80;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    xxh64_cfg_if    cfg_ch();
    xxh64_stripe_if stripe_ch();
    xxh64_digest_if digest_ch();

    xxhash_64bit_digest_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch.sink),
        .i_stripe(stripe_ch.sink),
        .o_digest(digest_ch.source)
    );

    // predictor state
    logic [63:0] seed_reg;
    logic [63:0] lanes [NUM_LANES];
    logic [63:0] total_bytes;
    logic        msg_open;

    logic [63:0] digest_queue[$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    function automatic logic [63:0] rol(logic [63:0] x, int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] lane_round(logic [63:0] acc, logic [63:0] w);
        return rol(acc + w * PRIME2, 31) * PRIME1;
    endfunction

    function automatic logic [63:0] byte_of(t_quad w, int i);
        return {56'd0, w[i / 8][(i % 8) * 8 +: 8]};
    endfunction

    // advance predictor by one stripe beat; returns 1 when a digest is produced
    function automatic bit predict_beat(t_quad w, logic [5:0] vb, logic fin,
                                        output logic [63:0] dg);
        int v, p;
        bit had;
        logic [63:0] h, k;
        dg = '0;
        if (!msg_open) begin
            lanes[0] = seed_reg + PRIME1 + PRIME2;
            lanes[1] = seed_reg + PRIME2;
            lanes[2] = seed_reg;
            lanes[3] = seed_reg - PRIME1;
            total_bytes = '0;
            msg_open = 1'b1;
        end
        had = total_bytes != 0;
        if (!fin) begin
            for (int i = 0; i < 4; i++) lanes[i] = lane_round(lanes[i], w[i]);
            total_bytes += 32;
            return 1'b0;
        end
        v = (vb > 32) ? 32 : int'(vb);
        if (v == 32) begin
            for (int i = 0; i < 4; i++) lanes[i] = lane_round(lanes[i], w[i]);
            total_bytes += 32;
            had = 1'b1;
            v = 0;
        end
        if (had) begin
            h = rol(lanes[0], 1) + rol(lanes[1], 7) + rol(lanes[2], 12) + rol(lanes[3], 18);
            for (int i = 0; i < 4; i++) begin
                h ^= lane_round(64'd0, lanes[i]);
                h = h * PRIME1 + PRIME4;
            end
        end else begin
            h = seed_reg + PRIME5;
        end
        h += total_bytes + 64'(v);
        p = 0;
        while (p + 8 <= v) begin
            h ^= lane_round(64'd0, w[p / 8]);
            h = rol(h, 27) * PRIME1 + PRIME4;
            p += 8;
        end
        if (p + 4 <= v) begin
            k = byte_of(w, p) | (byte_of(w, p + 1) << 8) | (byte_of(w, p + 2) << 16)
                | (byte_of(w, p + 3) << 24);
            h ^= k * PRIME1;
            h = rol(h, 23) * PRIME2 + PRIME3;
            p += 4;
        end
        while (p < v) begin
            h ^= byte_of(w, p) * PRIME5;
            h = rol(h, 11) * PRIME1;
            p++;
        end
        h ^= h >> 33;
        h *= PRIME2;
        h ^= h >> 29;
        h *= PRIME3;
        h ^= h >> 32;
        dg = h;
        msg_open = 1'b0;
        return 1'b1;
    endfunction

    // watchdog: cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((stripe_ch.valid && stripe_ch.ready) || (digest_ch.valid && digest_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("xxhash_64bit_digest_top regression: fail");
            $finish;
        end
    end

    // digest checker
    always @(posedge i_clk) begin
        if (i_rst_n && digest_ch.valid && digest_ch.ready) begin
            if (digest_queue.size() == 0) begin
                $error("digest: unexpected beat, actual %h", digest_ch.digest);
                fail_count++;
            end else begin
                if (digest_ch.digest !== digest_queue[0]) begin
                    $error("digest: expected %h actual %h", digest_queue[0], digest_ch.digest);
                    fail_count++;
                end
                void'(digest_queue.pop_front());
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n)
            digest_ch.ready <= 1'b0;
        else
            digest_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_seed(logic [63:0] s);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.seed_value <= s;
        do @(posedge i_clk); while (!cfg_ch.ready);
        seed_reg = s;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (digest_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // send one stripe beat, expectation queued on acceptance
    task automatic send_beat(t_quad w, logic [5:0] vb, logic fin,
                             bit has_known = 0, logic [63:0] known = '0);
        logic [63:0] dg;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            stripe_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        stripe_ch.valid <= 1'b1;
        {stripe_ch.stripe_word3, stripe_ch.stripe_word2,
         stripe_ch.stripe_word1, stripe_ch.stripe_word0} <= w;
        stripe_ch.valid_bytes <= vb;
        stripe_ch.is_final <= fin;
        do @(posedge i_clk); while (!stripe_ch.ready);
        if (predict_beat(w, vb, fin, dg)) begin
            if (has_known && dg !== known) begin
                $error("digest: predictor %h, table %h", dg, known);
                fail_count++;
            end
            digest_queue.push_back(has_known ? known : dg);
        end
        @(negedge i_clk);
        stripe_ch.valid <= 1'b0;
    endtask

    function automatic t_quad rand_quad();
        t_quad q;
        for (int i = 0; i < 4; i++) q[i] = {$urandom(), $urandom()};
        return q;
    endfunction

    // directed table: empty-message digests are fixed and known
    typedef struct {
        t_quad       words;
        logic [5:0]  vb;
        logic        fin;
        bit          known;
        logic [63:0] dg;
    } t_row;

    t_row rows[] = '{
        '{'0, 6'd0, 1'b1, 1'b1, 64'hEF46DB3751D8E999},       // empty, seed 0
        '{'1, 6'd1, 1'b1, 1'b0, '0},
        '{{4{64'hFFFF_FFFF_FFFF_FFFF}}, 6'd3, 1'b1, 1'b0, '0},
        '{{4{64'hFFFF_FFFF_FFFF_FFFF}}, 6'd4, 1'b1, 1'b0, '0},
        '{{4{64'h0123_4567_89AB_CDEF}}, 6'd7, 1'b1, 1'b0, '0},
        '{{4{64'h0123_4567_89AB_CDEF}}, 6'd8, 1'b1, 1'b0, '0},
        '{{4{64'hA5A5_A5A5_5A5A_5A5A}}, 6'd13, 1'b1, 1'b0, '0},
        '{{4{64'hFFFF_FFFF_FFFF_FFFF}}, 6'd31, 1'b1, 1'b0, '0},
        '{{4{64'hFFFF_FFFF_FFFF_FFFF}}, 6'd32, 1'b1, 1'b0, '0},
        '{{4{64'h1111_2222_3333_4444}}, 6'd63, 1'b1, 1'b0, '0}, // oversized count
        '{{4{64'hFFFF_FFFF_FFFF_FFFF}}, 6'd63, 1'b0, 1'b0, '0}, // count ignored
        '{'0, 6'd0, 1'b1, 1'b0, '0},                            // long, no tail
        '{{4{64'h8000_0000_0000_0001}}, 6'd0, 1'b0, 1'b0, '0},
        '{{4{64'h7FFF_FFFF_FFFF_FFFE}}, 6'd32, 1'b1, 1'b0, '0},
        '{'0, 6'd5, 1'b0, 1'b0, '0},
        '{'1, 6'd0, 1'b0, 1'b0, '0},
        '{{4{64'hDEAD_BEEF_CAFE_F00D}}, 6'd29, 1'b1, 1'b0, '0}
    };

    task automatic random_message(int max_stripes, output int nbeats);
        int n;
        logic [5:0] vb;
        n = ($urandom_range(9) == 0) ? $urandom_range(max_stripes) : $urandom_range(2);
        for (int i = 0; i < n; i++) send_beat(rand_quad(), 6'($urandom()), 1'b0);
        vb = ($urandom_range(15) == 0) ? 6'($urandom_range(63, 33)) : 6'($urandom_range(32));
        send_beat(rand_quad(), vb, 1'b1);
        nbeats = n + 1;
    endtask

    initial begin
        int beats;
        int msgs;
        int nb;
        cfg_ch.valid = 1'b0;
        cfg_ch.seed_value = '0;
        stripe_ch.valid = 1'b0;
        {stripe_ch.stripe_word3, stripe_ch.stripe_word2,
         stripe_ch.stripe_word1, stripe_ch.stripe_word0} = '0;
        stripe_ch.valid_bytes = '0;
        stripe_ch.is_final = 1'b0;
        digest_ch.ready = 1'b0;
        seed_reg = '0;
        total_bytes = '0;
        msg_open = 1'b0;
        for (int i = 0; i < 4; i++) lanes[i] = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        foreach (rows[i]) send_beat(rows[i].words, rows[i].vb, rows[i].fin,
                                    rows[i].known, rows[i].dg);
        wait_drained();

        // random phases over several seeds, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            case (ph)
                0: write_seed(64'd0);
                1: write_seed(64'hFFFF_FFFF_FFFF_FFFF);
                2: write_seed(64'd1);
                default: write_seed({$urandom(), $urandom()});
            endcase
            beats = 0;
            msgs = 0;
            while (beats < 222) begin
                random_message(12, nb);
                beats += nb;
                msgs++;
                if (ph == 2 && msgs % 20 == 0)
                    while (digest_queue.size() != 0) @(posedge i_clk);
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("xxhash_64bit_digest_top regression: pass");
        else
            $display("xxhash_64bit_digest_top regression: fail");
        $finish;
    end
endmodule
